// ===== design/quicksort_three_way_partition_core_macros.svh =====
// ----------------------------------------------------------------------------
// quicksort three-way partition core assertion macros
// shared property forms for the core's checks, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_THREE_WAY_PARTITION_CORE_MACROS_SVH
`define QUICKSORT_THREE_WAY_PARTITION_CORE_MACROS_SVH

// same-cycle implication, held off while in reset
`define QS3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define QS3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/qs3_pkg.sv =====
// ----------------------------------------------------------------------------
// qs3_pkg
// types and fixed widths shared by the three-way partition sort core
// ----------------------------------------------------------------------------
package qs3_pkg;

    // width of the value field on both channels
    localparam int VALUE_W = 32;
    // tuser carries the overflow flag only
    localparam int OUT_USER_W = 1;

    // result of the shared compare unit against the pivot
    typedef struct packed {
        logic less;
        logic greater;
    } cmp_res_t;

endpackage

// ===== design/qs3_ram.sv =====
// ----------------------------------------------------------------------------
// qs3_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module qs3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/qs3_cmp.sv =====
// ----------------------------------------------------------------------------
// qs3_cmp
// shared signed compare of one element against the current pivot
// ----------------------------------------------------------------------------
module qs3_cmp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic [DATA_WIDTH-1:0] elem,
    input  logic [DATA_WIDTH-1:0] pivot,
    output qs3_pkg::cmp_res_t     res
);

    import qs3_pkg::*;

    assign res.less    = $signed(elem) < $signed(pivot);
    assign res.greater = $signed(elem) > $signed(pivot);

endmodule

// ===== design/quicksort_three_way_partition_core.sv =====
// ----------------------------------------------------------------------------
// quicksort_three_way_partition_core
// loads a set of signed words, sorts it in place with three-way quicksort,
// then streams the sorted set out
// ----------------------------------------------------------------------------
// usage
//   s_ side: one signed word per beat in s_tdata, s_tlast closes the set.
//   loading takes one word per cycle; words beyond CAPACITY are dropped and
//   flagged. after the closing word s_tready stays low until the last sorted
//   word has been taken on the m_ side.
//   sort: ranges come off a range stack, the pivot is the middle element, and
//   one pass splits the range into less / equal / greater. each element visit
//   reads the element and compares it against the pivot; a visit that needs
//   a swap then writes the partner word into the scan slot and the scanned
//   word into the partner slot. each range also passes through pop, pivot
//   read, scan exit and pushes.
//   m_ side: one sorted word per beat, m_tlast on the last, m_tuser[0] is the
//   overflow flag of the set. each word is read and registered, then held in
//   the output register until m_tready; the next word is read after that.
//   reset (aresetn low, synchronous) empties the set and clears the flag;
//   memory contents are not cleared, only entries of the current set are read.
// ----------------------------------------------------------------------------
module quicksort_three_way_partition_core #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: [31:0] value
    input  logic [qs3_pkg::VALUE_W-1:0]        s_tdata,
    input  logic                               s_tlast,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: [31:0] value_res
    output logic [qs3_pkg::VALUE_W-1:0]        m_tdata,
    output logic                               m_tlast,
    // m_tuser: [0] overflow
    output logic [qs3_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    import qs3_pkg::*;

`include "quicksort_three_way_partition_core_macros.svh"

    localparam int AW = $clog2(CAPACITY);       // element / stack address
    localparam int CW = $clog2(CAPACITY + 1);   // counts and range bounds
    localparam int EW = 2 * CW;                 // stack entry {hi, lo}

    // sequencer states
    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_POP   = 4'd2;
    localparam logic [3:0] ST_POPD  = 4'd3;
    localparam logic [3:0] ST_PIV   = 4'd4;
    localparam logic [3:0] ST_LOOP  = 4'd5;
    localparam logic [3:0] ST_CMP   = 4'd6;
    localparam logic [3:0] ST_SWPA  = 4'd7;
    localparam logic [3:0] ST_SWPB  = 4'd8;
    localparam logic [3:0] ST_PUSH1 = 4'd9;
    localparam logic [3:0] ST_PUSH2 = 4'd10;
    localparam logic [3:0] ST_ERD   = 4'd11;
    localparam logic [3:0] ST_EOUT  = 4'd12;
    localparam logic [3:0] ST_EWAIT = 4'd13;

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  dropped_reg, dropped_next;
    logic [CW-1:0]         sp_reg, sp_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         lt_reg, lt_next;     // end of the less part
    logic [CW-1:0]         i_reg, i_next;       // scan position
    logic [CW-1:0]         gt_reg, gt_next;     // start of the greater part
    logic [AW-1:0]         tgt_reg, tgt_next;   // swap partner
    logic                  less_reg, less_next;
    logic [AW-1:0]         e_reg, e_next;       // emit index
    logic [DATA_WIDTH-1:0] cur_reg, cur_next;
    logic [DATA_WIDTH-1:0] pivot_reg, pivot_next;
    logic [VALUE_W-1:0]    out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_ovf_reg, out_ovf_next;

    // element memory port
    logic                  st_wr_en;
    logic [AW-1:0]         st_wr_addr;
    logic [DATA_WIDTH-1:0] st_wr_data;
    logic [AW-1:0]         st_rd_addr;
    logic [DATA_WIDTH-1:0] st_rd_data;

    // range stack port
    logic                  stk_wr_en;
    logic [AW-1:0]         stk_wr_addr;
    logic [EW-1:0]         stk_wr_data;
    logic [AW-1:0]         stk_rd_addr;
    logic [EW-1:0]         stk_rd_data;
    logic [CW-1:0]         stk_lo, stk_hi, stk_mid;
    logic [CW-1:0]         sp_dec;

    logic [DATA_WIDTH-1:0] in_key;
    logic [VALUE_W-1:0]    out_val;
    cmp_res_t              cmp_res;
    logic                  s_fire, m_fire;

    // address of the word just below the greater part
    function automatic logic [AW-1:0] sp_word(input logic [CW-1:0] bound);
        logic [CW-1:0] dec;
        dec     = bound - CW'(1);
        sp_word = dec[AW-1:0];
    endfunction

    qs3_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    qs3_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // the one compare unit: word just read against the pivot
    qs3_cmp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cmp (
        .elem  (st_rd_data),
        .pivot (pivot_reg),
        .res   (cmp_res)
    );

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EWAIT);
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = OUT_USER_W'(out_ovf_reg);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    // sign-extend or truncate the incoming word to the stored key width
    always_comb begin
        for (int j = 0; j < DATA_WIDTH; j++) begin
            in_key[j] = s_tdata[(j < VALUE_W) ? j : VALUE_W - 1];
        end
    end

    // stored key back to a 32-bit word
    always_comb begin
        for (int j = 0; j < VALUE_W; j++) begin
            out_val[j] = st_rd_data[(j < DATA_WIDTH) ? j : DATA_WIDTH - 1];
        end
    end

    assign stk_lo      = stk_rd_data[CW-1:0];
    assign stk_hi      = stk_rd_data[EW-1:CW];
    assign stk_mid     = stk_lo + ((stk_hi - stk_lo) >> 1);
    assign sp_dec      = sp_reg - CW'(1);
    assign stk_rd_addr = sp_dec[AW-1:0];
    assign stk_wr_addr = sp_reg[AW-1:0];

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        sp_next       = sp_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        lt_next       = lt_reg;
        i_next        = i_reg;
        gt_next       = gt_reg;
        tgt_next      = tgt_reg;
        less_next     = less_reg;
        e_next        = e_reg;
        cur_next      = cur_reg;
        pivot_next    = pivot_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_ovf_next  = out_ovf_reg;

        st_wr_en      = 1'b0;
        st_wr_addr    = count_reg[AW-1:0];
        st_wr_data    = in_key;
        st_rd_addr    = i_reg[AW-1:0];
        stk_wr_en     = 1'b0;
        stk_wr_data   = {hi_reg, lo_reg};

        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (count_reg < CW'(CAPACITY)) begin
                        st_wr_en   = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                // whole set is the first range
                e_next  = '0;
                sp_next = '0;
                if (count_reg >= CW'(2)) begin
                    stk_wr_en   = 1'b1;
                    stk_wr_data = {count_reg, CW'(0)};
                    sp_next     = CW'(1);
                    state_next  = ST_POP;
                end else begin
                    state_next = ST_ERD;
                end
            end
            ST_POP: begin
                if (sp_reg == '0) begin
                    e_next     = '0;
                    state_next = ST_ERD;
                end else begin
                    sp_next    = sp_dec;
                    state_next = ST_POPD;
                end
            end
            ST_POPD: begin
                lo_next    = stk_lo;
                hi_next    = stk_hi;
                st_rd_addr = stk_mid[AW-1:0];
                state_next = ST_PIV;
            end
            ST_PIV: begin
                pivot_next = st_rd_data;
                lt_next    = lo_reg;
                i_next     = lo_reg;
                gt_next    = hi_reg;
                state_next = ST_LOOP;
            end
            ST_LOOP: begin
                if (i_reg < gt_reg) begin
                    st_rd_addr = i_reg[AW-1:0];
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_PUSH1;
                end
            end
            ST_CMP: begin
                cur_next = st_rd_data;
                if (cmp_res.less) begin
                    less_next = 1'b1;
                    if (lt_reg == i_reg) begin
                        lt_next    = lt_reg + CW'(1);
                        i_next     = i_reg + CW'(1);
                        state_next = ST_LOOP;
                    end else begin
                        tgt_next   = lt_reg[AW-1:0];
                        st_rd_addr = lt_reg[AW-1:0];
                        state_next = ST_SWPA;
                    end
                end else if (cmp_res.greater) begin
                    less_next  = 1'b0;
                    tgt_next   = sp_word(gt_reg);
                    st_rd_addr = sp_word(gt_reg);
                    state_next = ST_SWPA;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_LOOP;
                end
            end
            ST_SWPA: begin
                // partner word into the scan slot
                st_wr_en   = 1'b1;
                st_wr_addr = i_reg[AW-1:0];
                st_wr_data = st_rd_data;
                state_next = ST_SWPB;
            end
            ST_SWPB: begin
                st_wr_en   = 1'b1;
                st_wr_addr = tgt_reg;
                st_wr_data = cur_reg;
                if (less_reg) begin
                    lt_next = lt_reg + CW'(1);
                    i_next  = i_reg + CW'(1);
                end else begin
                    gt_next = gt_reg - CW'(1);
                end
                state_next = ST_LOOP;
            end
            ST_PUSH1: begin
                // less part
                if ((lt_reg - lo_reg) >= CW'(2) && sp_reg < CW'(CAPACITY)) begin
                    stk_wr_en   = 1'b1;
                    stk_wr_data = {lt_reg, lo_reg};
                    sp_next     = sp_reg + CW'(1);
                end
                state_next = ST_PUSH2;
            end
            ST_PUSH2: begin
                // greater part
                if ((hi_reg - gt_reg) >= CW'(2) && sp_reg < CW'(CAPACITY)) begin
                    stk_wr_en   = 1'b1;
                    stk_wr_data = {hi_reg, gt_reg};
                    sp_next     = sp_reg + CW'(1);
                end
                state_next = ST_POP;
            end
            ST_ERD: begin
                st_rd_addr = e_reg;
                state_next = ST_EOUT;
            end
            ST_EOUT: begin
                out_data_next = out_val;
                out_last_next = ((CW'(e_reg) + CW'(1)) == count_reg);
                out_ovf_next  = dropped_reg;
                state_next    = ST_EWAIT;
            end
            ST_EWAIT: begin
                if (m_fire) begin
                    if (out_last_reg) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        sp_next      = '0;
                        state_next   = ST_LOAD;
                    end else begin
                        e_next     = e_reg + AW'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            sp_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            sp_reg      <= sp_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        lt_reg       <= lt_next;
        i_reg        <= i_next;
        gt_reg       <= gt_next;
        tgt_reg      <= tgt_next;
        less_reg     <= less_next;
        e_reg        <= e_next;
        cur_reg      <= cur_next;
        pivot_reg    <= pivot_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // never loading and emitting at once
    `QS3_ASSERT_NOW(a_load_emit_excl, s_tready, !m_tvalid, "load and emit overlap")
    // partition bounds stay ordered while scanning
    `QS3_ASSERT_NOW(a_part_order, state_reg == ST_LOOP,
        lt_reg <= i_reg && i_reg <= gt_reg && gt_reg <= hi_reg, "partition bounds out of order")
    // range stack never runs past its depth
    `QS3_ASSERT_NOW(a_stack_depth, 1'b1, sp_reg <= CW'(CAPACITY), "range stack overrun")
    // after the final word is taken the block is ready to load again
    `QS3_ASSERT_NEXT(a_reload, m_fire && m_tlast, s_tready && count_reg == '0,
        "not back to load after final word")

endmodule
